// ===== hdl/pip_pkg.sv =====
// Shared types, constants and helper functions for the point-in-polygon crossing core.
// No dependencies; pip_if, pip_front, pip_back and the top level use this package.
`timescale 1ns / 1ps

package pip_pkg;

    localparam int FIELD_W         = 32;
    localparam int COORD_W_DEF     = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Outcome of the sign tests for one crossing rule.
    typedef struct packed {
        logic need_mul;     // signs straddle both axes: the cross product decides
        logic fixed_cross;  // crossing result when no product is needed
        logic y1_nonneg;    // end vertex y is zero or positive
    } t_rule_cls;

    localparam int RCLS_W = $bits(t_rule_cls);

    function automatic t_rule_cls f_classify(input logic x0_neg, input logic y0_neg,
                                             input logic x1_neg, input logic y1_neg);
        t_rule_cls r;
        r.need_mul    = 1'b0;
        r.fixed_cross = 1'b0;
        r.y1_nonneg   = !y1_neg;
        if (y0_neg != y1_neg) begin
            if (x0_neg == x1_neg) begin
                r.fixed_cross = x0_neg;
            end else begin
                r.need_mul = 1'b1;
            end
        end
        return r;
    endfunction

    // Width of one queued job: eight translated coordinates, two rule outcomes,
    // the vertex hit and the last-edge mark.
    function automatic int f_job_w(input int cw);
        return 8 * (cw + 1) + 2 * RCLS_W + 2;
    endfunction

endpackage

// ===== hdl/pip_if.sv =====
// Valid/ready channel interfaces for the edge input and the result output.
// Depends on pip_pkg for the field width.
`timescale 1ns / 1ps

interface pip_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pip_pkg::FIELD_W-1:0]  point_x;
    logic signed [pip_pkg::FIELD_W-1:0]  point_y;
    logic signed [pip_pkg::FIELD_W-1:0]  start_x;
    logic signed [pip_pkg::FIELD_W-1:0]  start_y;
    logic signed [pip_pkg::FIELD_W-1:0]  end_x;
    logic signed [pip_pkg::FIELD_W-1:0]  end_y;
    logic                                last_edge;

    modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    last_edge, input ready);
    modport sink   (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    last_edge, output ready);
endinterface

interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic on_vertex;

    modport source (output valid, inside_res, on_vertex, input ready);
    modport sink   (input valid, inside_res, on_vertex, output ready);
endinterface

// ===== hdl/pip_fifo.sv =====
// Short job queue between the classifying front end and the arithmetic back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module pip_fifo #(
    parameter int DEPTH  = 4,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not fall on a lone pop");

endmodule

// ===== hdl/pip_front.sv =====
// Front end: takes an edge word, translates it to the query point for both rules,
// classifies each rule by sign tests and flags an exact vertex hit. Uses pip_pkg.
`timescale 1ns / 1ps

module pip_front #(
    parameter int COORD_WIDTH = pip_pkg::COORD_W_DEF
) (
    pip_in_if.sink                                    i_in,
    input  logic                                      i_full,
    output logic                                      o_push,
    output logic [pip_pkg::f_job_w(COORD_WIDTH)-1:0]  o_job
);
    import pip_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    typedef struct packed {
        logic signed [DW-1:0] cx0, cy0, cx1, cy1;
        logic signed [DW-1:0] hx0, hy0, hx1, hy1;
        t_rule_cls            cls_c;
        t_rule_cls            cls_h;
        logic                 vhit;
        logic                 last;
    } t_job;

    logic signed [COORD_WIDTH-1:0] px, py, sx, sy, ex, ey;
    logic signed [DW-1:0]          px_w, py_w, sx_w, sy_w, ex_w, ey_w;
    t_job                          job;

    // Only the low coordinate bits count; they are sign extended by one bit.
    assign px = i_in.point_x[COORD_WIDTH-1:0];
    assign py = i_in.point_y[COORD_WIDTH-1:0];
    assign sx = i_in.start_x[COORD_WIDTH-1:0];
    assign sy = i_in.start_y[COORD_WIDTH-1:0];
    assign ex = i_in.end_x[COORD_WIDTH-1:0];
    assign ey = i_in.end_y[COORD_WIDTH-1:0];

    assign px_w = DW'(px);
    assign py_w = DW'(py);
    assign sx_w = DW'(sx);
    assign sy_w = DW'(sy);
    assign ex_w = DW'(ex);
    assign ey_w = DW'(ey);

    // The half-open coordinate a - p - 1 equals a + ~p, so it needs no second add.
    always_comb begin
        job.cx0   = sx_w - px_w;
        job.cy0   = sy_w - py_w;
        job.cx1   = ex_w - px_w;
        job.cy1   = ey_w - py_w;
        job.hx0   = sx_w + ~px_w;
        job.hy0   = sy_w + ~py_w;
        job.hx1   = ex_w + ~px_w;
        job.hy1   = ey_w + ~py_w;
        job.cls_c = f_classify(job.cx0[DW-1], job.cy0[DW-1], job.cx1[DW-1], job.cy1[DW-1]);
        job.cls_h = f_classify(job.hx0[DW-1], job.hy0[DW-1], job.hx1[DW-1], job.hy1[DW-1]);
        job.vhit  = ((job.cx0 == '0) && (job.cy0 == '0)) ||
                    ((job.cx1 == '0) && (job.cy1 == '0));
        job.last  = i_in.last_edge;
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_job      = job;

endmodule

// ===== hdl/pip_back.sv =====
// Back end: cross products for both rules, then the sign decision, parity
// accumulation and the result register. Uses pip_pkg and pip_out_if.
`timescale 1ns / 1ps

module pip_back #(
    parameter int COORD_WIDTH = pip_pkg::COORD_W_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_empty,
    output logic                                      o_pop,
    input  logic [pip_pkg::f_job_w(COORD_WIDTH)-1:0]  i_job,
    pip_out_if.source                                 o_out
);
    import pip_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    typedef struct packed {
        logic signed [DW-1:0] cx0, cy0, cx1, cy1;
        logic signed [DW-1:0] hx0, hy0, hx1, hy1;
        t_rule_cls            cls_c;
        t_rule_cls            cls_h;
        logic                 vhit;
        logic                 last;
    } t_job;

    t_job                 job;
    logic                 en;
    logic                 r_a_valid;
    logic signed [PW-1:0] r_pc, r_qc, r_ph, r_qh;
    t_rule_cls            r_cls_c, r_cls_h;
    logic                 r_a_vhit, r_a_last;
    logic                 cross_c, cross_h;
    logic                 n_par_c, n_par_h, n_vhit;
    logic                 r_par_c, r_par_h, r_vhit;
    logic                 r_out_valid, r_inside, r_on_vertex;

    assign job   = t_job'(i_job);
    // The whole back end moves unless a result waits that is not being taken.
    assign en    = !r_out_valid || o_out.ready;
    assign o_pop = en && !i_empty;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pc     <= PW'(job.cx0) * PW'(job.cy1);
            r_qc     <= PW'(job.cx1) * PW'(job.cy0);
            r_ph     <= PW'(job.hx0) * PW'(job.hy1);
            r_qh     <= PW'(job.hx1) * PW'(job.hy0);
            r_cls_c  <= job.cls_c;
            r_cls_h  <= job.cls_h;
            r_a_vhit <= job.vhit;
            r_a_last <= job.last;
        end
    end

    // Where the signs do not settle it, an edge crosses when the cross product sign disagrees with the end vertex side.
    always_comb begin
        cross_c = r_cls_c.need_mul ? ((r_pc >= r_qc) ^ r_cls_c.y1_nonneg)
                                   : r_cls_c.fixed_cross;
        cross_h = r_cls_h.need_mul ? ((r_ph >= r_qh) ^ r_cls_h.y1_nonneg)
                                   : r_cls_h.fixed_cross;
        n_par_c = r_par_c ^ cross_c;
        n_par_h = r_par_h ^ cross_h;
        n_vhit  = r_vhit | r_a_vhit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_par_c     <= 1'b0;
            r_par_h     <= 1'b0;
            r_vhit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en && r_a_valid && r_a_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (en) begin
                r_a_valid <= o_pop;
                if (r_a_valid) begin
                    if (r_a_last) begin
                        r_par_c <= 1'b0;
                        r_par_h <= 1'b0;
                        r_vhit  <= 1'b0;
                    end else begin
                        r_par_c <= n_par_c;
                        r_par_h <= n_par_h;
                        r_vhit  <= n_vhit;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_a_valid && r_a_last) begin
            r_inside    <= n_par_c | n_par_h | n_vhit;
            r_on_vertex <= n_vhit;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.inside_res = r_inside;
    assign o_out.on_vertex  = r_on_vertex;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_a_valid && r_a_last) |=> (!r_par_c && !r_par_h && !r_vhit && r_out_valid))
        else $error("polygon state not cleared after the closing edge");

    a_vertex_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_on_vertex) |-> r_inside)
        else $error("vertex hit reported without inside");

endmodule

// ===== hdl/point_in_polygon_crossing_core.sv =====
// Top level of the even-odd point-in-polygon core: front end, job queue, back end.
// Depends on pip_pkg, pip_if, pip_fifo, pip_front and pip_back.
//
//  Port     Dir   Word                                                   Handshake
//  i_in     in    point, edge start, edge end, last_edge                 valid/ready
//  o_out    out   inside_res, on_vertex (once per polygon, closing edge) valid/ready
//
// One edge word is taken per cycle while i_in.ready is high; a closing edge passes
// through the queue write, the product register and the result register to its result.
// Reset (synchronous, active low) empties the queue and clears the parity and hit bits.
// A result that is not taken stalls the back end; the queue then absorbs up to
// QUEUE_DEPTH words before i_in.ready falls.
`timescale 1ns / 1ps

module point_in_polygon_crossing_core #(
    parameter int COORD_WIDTH = pip_pkg::COORD_W_DEF,
    parameter int QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pip_in_if.sink    i_in,
    pip_out_if.source o_out
);
    import pip_pkg::*;

    localparam int JOB_W = f_job_w(COORD_WIDTH);

    logic             push, pop, full, empty;
    logic [JOB_W-1:0] job_in, job_out;

    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_job  (job_in)
    );

    pip_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    pip_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .o_pop   (pop),
        .i_job   (job_out),
        .o_out   (o_out)
    );

endmodule
